@@ rtl/fnv1a_hash_bucket_select_defines.svh @@
// ----------------------------------------------------------------------------
// fnv1a hash bucket select assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef FNV1A_HASH_BUCKET_SELECT_DEFINES_SVH
`define FNV1A_HASH_BUCKET_SELECT_DEFINES_SVH

// same-cycle implication
`define FHBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FHBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fhbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhbs_pkg
// types, constants and the prime multiply shared by the fnv1a hash block
// ----------------------------------------------------------------------------
package fhbs_pkg;

  localparam int HASH_W   = 64;
  localparam int BUCKET_W = 32;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
  // prime is 2^40 + 0x1b3
  localparam logic [HASH_W-1:0] FNV_PRIME        = 64'h0000_0100_0000_01B3;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(HASH_W - 1);

  typedef enum logic [2:0] {
    ST_HASH = 3'b001,
    ST_DIV  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic div_start;
    logic div_step;
    logic load_div;
  } cmd_t;

  typedef struct packed {
    logic bucket_zero;
    logic out_free;
  } sts_t;

  // multiply by the fnv prime mod 2^64 as a sum of shifted copies
  function automatic logic [HASH_W-1:0] fnv_mul_prime(input logic [HASH_W-1:0] x);
    fnv_mul_prime = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                  + (x << 1) + x;
  endfunction

endpackage

@@ rtl/fhbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhbs_ctrl
// sequencer: byte intake, remainder steps and result hand-off
// ----------------------------------------------------------------------------
`include "fnv1a_hash_bucket_select_defines.svh"

module fhbs_ctrl
  import fhbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic last_byte,
  input  logic empty_key,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             is_final;
  logic             is_direct;

  assign is_final  = last_byte | empty_key;
  assign is_direct = empty_key | sts.bucket_zero;

  // a final item that needs no divide must find the output slot free
  assign in_ready = (state == ST_HASH) & (~is_final | ~is_direct | sts.out_free);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cmd             = '0;
    cmd.accept      = in_valid & in_ready;
    case (state)
      ST_HASH: begin
        if (cmd.accept && is_final) begin
          if (is_direct) begin
            cmd.load_direct = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
            cnt_next      = '0;
            state_next    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.out_free) begin
          cmd.load_div = 1'b1;
          state_next   = ST_HASH;
        end
      end
      default: begin
        state_next = ST_HASH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HASH;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `FHBS_ASSERT_NEXT(a_div_entry, cmd.div_start, (state == ST_DIV) && (cnt == '0), "divide did not start from step zero")
  `FHBS_ASSERT_NEXT(a_div_length, (state == ST_DIV) && (cnt == DIV_LAST), state == ST_WAIT, "divide did not end after last step")
  `FHBS_ASSERT_NOW(a_load_slot, cmd.load_direct || cmd.load_div, sts.out_free, "result loaded over a pending item")
  `FHBS_ASSERT_NEXT(a_wait_exit, (state == ST_WAIT) && sts.out_free, state == ST_HASH, "remainder result not handed off")

endmodule

@@ rtl/fhbs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhbs_dp
// running hash, bit-serial remainder unit, bucket register and output stage
// ----------------------------------------------------------------------------
module fhbs_dp
  import fhbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [BYTE_W-1:0]   key_byte,
  input  logic                last_byte,
  input  logic                empty_key,
  input  logic                cfg_we,
  input  logic [BUCKET_W-1:0] cfg_wdata,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HASH_W-1:0]   key_hash,
  output logic [BUCKET_W-1:0] bucket_index
);

  logic [HASH_W-1:0]   running_hash;
  logic [HASH_W-1:0]   hash_next;
  logic [HASH_W-1:0]   final_hash;
  logic [HASH_W-1:0]   dividend;
  logic [BUCKET_W-1:0] bucket_count;
  logic [BUCKET_W-1:0] rem;
  logic [BUCKET_W:0]   rem_sh;
  logic [BUCKET_W:0]   rem_diff;

  assign hash_next = fnv_mul_prime(running_hash ^ HASH_W'(key_byte));

  // remainder stays below the bucket count, so one extra bit covers the shift
  assign rem_sh   = {rem, dividend[HASH_W-1]};
  assign rem_diff = rem_sh - {1'b0, bucket_count};

  assign sts.bucket_zero = (bucket_count == '0);
  assign sts.out_free    = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_OFFSET_BASIS;
      bucket_count <= BUCKET_W'(1);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_wdata;
      end
      if (cmd.accept) begin
        if (last_byte || empty_key) begin
          running_hash <= FNV_OFFSET_BASIS;
        end else begin
          running_hash <= hash_next;
        end
      end
      if (cmd.load_direct || cmd.load_div) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      final_hash <= hash_next;
      dividend   <= hash_next;
      rem        <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend << 1;
      if (!rem_diff[BUCKET_W]) begin
        rem <= rem_diff[BUCKET_W-1:0];
      end else begin
        rem <= rem_sh[BUCKET_W-1:0];
      end
    end
    if (cmd.load_direct) begin
      key_hash     <= empty_key ? '0 : hash_next;
      bucket_index <= '0;
    end else if (cmd.load_div) begin
      key_hash     <= final_hash;
      bucket_index <= rem;
    end
  end

endmodule

@@ rtl/fnv1a_hash_bucket_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1a_hash_bucket_select
// 64-bit fnv-1a key hash with bucket index reduction
// ----------------------------------------------------------------------------
// Key bytes enter one per cycle on a valid/ready channel while in_ready is
// high; the final byte (last_byte) or an empty-key marker produces one item
// with the 64-bit hash and the hash modulo bucket_count. A final byte with a
// nonzero bucket_count runs a one-bit-per-cycle remainder unit: the next item
// can be accepted only after its 64 remainder steps and the hand-off, or
// later while the output item is still held. Empty keys and a zero
// bucket_count skip the remainder and load the output register directly.
// The result sits in an output register, so the next key's bytes may start
// while it waits. Write bucket_count (cfg_we) only while the block is idle;
// it resets to 1.
// ----------------------------------------------------------------------------
module fnv1a_hash_bucket_select
  import fhbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   key_byte,
  input  logic                last_byte,
  input  logic                empty_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HASH_W-1:0]   key_hash,
  output logic [BUCKET_W-1:0] bucket_index,
  input  logic                cfg_we,
  input  logic [BUCKET_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  fhbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_byte (last_byte),
    .empty_key (empty_key),
    .sts       (sts),
    .cmd       (cmd)
  );

  fhbs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .key_byte     (key_byte),
    .last_byte    (last_byte),
    .empty_key    (empty_key),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_hash     (key_hash),
    .bucket_index (bucket_index)
  );

endmodule

@@ verif/fnv1a_hash_bucket_select_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1a_hash_bucket_select_test
// self-checking bench for the fnv-1a 64-bit hash and bucket index block
// ----------------------------------------------------------------------------
// Keys are streamed a byte at a time with bursty input gaps and a rotating
// output stall pattern. A local hash model predicts key_hash and bucket_index
// for every final byte or empty-key marker; the checker compares each output
// item with the oldest prediction. Bucket counts of 1, 0, all ones and
// several others are applied between phases while the block is idle.
// ----------------------------------------------------------------------------
module fnv1a_hash_bucket_select_test;
  import fhbs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 80;   // outlasts a remainder unit operation
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [HASH_W-1:0]   hash;
    logic [BUCKET_W-1:0] bucket;
  } hash_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   key_byte;
  logic                last_byte;
  logic                empty_key;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [HASH_W-1:0]   key_hash;
  logic [BUCKET_W-1:0] bucket_index;
  logic                cfg_we;
  logic [BUCKET_W-1:0] cfg_wdata;

  // hash model state
  logic [HASH_W-1:0]   model_hash;
  logic [BUCKET_W-1:0] model_buckets;
  hash_result_t        pending_hashes[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  sender_idle = 1'b1;
  bit  stall_en = 1'b1;
  logic [15:0] stall_pat = 16'h0000;
  logic [7:0]  pat_age = 8'd0;

  fnv1a_hash_bucket_select dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_byte     (key_byte),
    .last_byte    (last_byte),
    .empty_key    (empty_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_hash     (key_hash),
    .bucket_index (bucket_index),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls follow a rotating pattern, refreshed whenever pat_age wraps, while stall_en is set
  always @(posedge clk) begin
    pat_age <= pat_age + 8'd1;
    if (pat_age == 8'd0) begin
      stall_pat <= 16'($urandom) & 16'h7fff;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[15:1]};
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_en) begin
      out_ready <= ~stall_pat[0];
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input logic [HASH_W-1:0] want,
                               input logic [HASH_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h at cycle %0d", what, want, got,
               cycle_count);
  endtask

  always @(posedge clk) begin : check_results
    hash_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_hashes.size() == 0) begin
        note_mismatch("unexpected item hash", '0, key_hash);
      end else begin
        want = pending_hashes.pop_front();
        if (key_hash !== want.hash)
          note_mismatch("key_hash", want.hash, key_hash);
        if (bucket_index !== want.bucket)
          note_mismatch("bucket_index", HASH_W'(want.bucket), HASH_W'(bucket_index));
      end
    end
  end

  // folds one accepted item into the model hash; returns 1 when it completes a key
  function automatic bit absorb_key_item(input logic [BYTE_W-1:0] b, input logic last,
                                         input logic empty, output hash_result_t r);
    logic [HASH_W-1:0] h;
    r.hash = '0;
    r.bucket = '0;
    if (empty) begin
      model_hash = FNV_OFFSET_BASIS;
      return 1'b1;
    end
    h = (model_hash ^ HASH_W'(b)) * FNV_PRIME;
    if (!last) begin
      model_hash = h;
      return 1'b0;
    end
    model_hash = FNV_OFFSET_BASIS;
    r.hash = h;
    if (model_buckets != '0)
      r.bucket = BUCKET_W'(h % HASH_W'(model_buckets));
    return 1'b1;
  endfunction

  task automatic send_key_item(input logic [BYTE_W-1:0] b, input logic last,
                               input logic empty);
    int gap;
    hash_result_t r;
    if (sender_idle && burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    key_byte  <= b;
    last_byte <= last;
    empty_key <= empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (absorb_key_item(b, last, empty, r))
      pending_hashes.push_back(r);
    if (burst_left > 0)
      burst_left--;
  endtask

  task automatic send_key(input int len);
    for (int i = 0; i < len; i++)
      send_key_item(BYTE_W'($urandom_range(0, 255)), i == len - 1, 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [BUCKET_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    model_buckets = value;
    cfg_we <= 1'b0;
  endtask

  // reset bucket count of 1, byte extremes, empty keys and a discarded partial key
  task automatic test_basic_keys();
    send_key_item(8'h00, 1'b1, 1'b0);
    send_key_item(8'hff, 1'b1, 1'b0);
    send_key_item(8'ha5, 1'b0, 1'b1);
    send_key_item(8'hff, 1'b1, 1'b1);
    write_bucket_count(32'd7);
    send_key_item(8'h61, 1'b0, 1'b0);
    send_key_item(8'h62, 1'b0, 1'b0);
    send_key_item(8'h63, 1'b1, 1'b0);
    // partial key dropped by an empty-key marker
    send_key_item(8'h55, 1'b0, 1'b0);
    send_key_item(8'haa, 1'b0, 1'b0);
    send_key_item(8'h3c, 1'b1, 1'b1);
    send_key_item(8'h80, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++)
      send_key_item(8'hff, i == 3, 1'b0);
  endtask

  task automatic test_zero_buckets();
    write_bucket_count(32'd0);
    send_key_item(8'h01, 1'b1, 1'b0);
    send_key_item(8'hfe, 1'b0, 1'b0);
    send_key_item(8'h7f, 1'b1, 1'b0);
  endtask

  task automatic test_max_buckets();
    write_bucket_count(32'hffff_ffff);
    send_key_item(8'h00, 1'b0, 1'b0);
    send_key_item(8'hff, 1'b1, 1'b0);
    send_key_item(8'h5a, 1'b1, 1'b0);
  endtask

  // mostly well-formed keys; some empty keys and partial keys dropped by an empty-key marker
  task automatic run_random_keys(input logic [BUCKET_W-1:0] buckets, input bit idle_in,
                                 input bit idle_out, input int n_items);
    int sent;
    int pick;
    int len;
    write_bucket_count(buckets);
    sender_idle = idle_in;
    stall_en <= idle_out;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = ($urandom_range(0, 99) < 95) ? $urandom_range(1, 8) : $urandom_range(9, 48);
        send_key(len);
        sent += len;
      end else if (pick < 90) begin
        send_key_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom), 1'b1);
        sent++;
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          send_key_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_key_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom), 1'b1);
        sent += len + 1;
      end
    end
  endtask

  task automatic test_random_keys();
    run_random_keys(32'd1, 1'b1, 1'b1, 118);
    run_random_keys(32'd0, 1'b0, 1'b1, 118);
    run_random_keys(32'hffff_ffff, 1'b1, 1'b0, 118);
    run_random_keys(32'd2, 1'b0, 1'b0, 118);
    run_random_keys(32'h8000_0000, 1'b1, 1'b1, 118);
    run_random_keys(BUCKET_W'($urandom_range(3, 1000)), 1'b1, 1'b1, 118);
    run_random_keys(BUCKET_W'($urandom), 1'b1, 1'b1, 118);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    key_byte  = '0;
    last_byte = 1'b0;
    empty_key = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    model_hash    = FNV_OFFSET_BASIS;
    model_buckets = 32'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_keys();
    test_zero_buckets();
    test_max_buckets();
    test_random_keys();

    wait_idle();
    if (pending_hashes.size() != 0)
      note_mismatch("items never produced", '0, HASH_W'(pending_hashes.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
